@@ hw/rtl/rvq_pkg.sv @@
package rvq_pkg;

   // CORDIC working vector, all Q2.30 with headroom
   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] a;
   } cordic_vec_type;

   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

endpackage

@@ hw/rtl/rotation_vector_to_quaternion.sv @@
// Throughput: one transaction per cycle; busy is low except during reset.
// The pipeline is built from the cell chains: 32 root cells, 31 axis divider cells,
// CORDIC_STEPS rotation cells, 32 root cells and 32 quotient cells, plus 11 stages.
// Reset (synchronous) empties the pipeline; the receiver cannot stall, so no backpressure.
module rotation_vector_to_quaternion import rvq_pkg::*; #(
   parameter int CORDIC_STEPS = 28
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_rot_x,
   input  logic [31:0] req_rot_y,
   input  logic [31:0] req_rot_z,
   output logic        rsp_valid,
   output logic [31:0] rsp_quat_x,
   output logic [31:0] rsp_quat_y,
   output logic [31:0] rsp_quat_z,
   output logic [31:0] rsp_quat_w,
   output logic        rsp_degenerate
);

   localparam logic [37:0] TWO_PI_38 = 38'd6746518852;
   localparam logic signed [33:0] TWO_PI  = 34'sd6746518852;
   localparam logic signed [33:0] PI      = 34'sd3373259426;
   localparam logic signed [33:0] HALF_PI = 34'sd1686629713;
   localparam logic signed [39:0] ONE_Q30 = 40'sd1073741824;
   localparam logic signed [39:0] TR_MAX  = 40'sd8589934592;
   localparam logic [31:0] S_MIN = 32'd262144;
   localparam int LATENCY = 138 + CORDIC_STEPS;
   localparam int CSW = 98;   // {k0, k1, k2, flip, zero}

   function automatic logic [31:0] umag32(input logic [31:0] v);
      umag32 = v[31] ? 32'(-v) : v;
   endfunction

   // the pipeline refuses work only during reset
   assign busy = reset;

   // ---------------- input and sum of squares ----------------
   logic        in_valid_ff;
   logic [95:0] rvec0_ff, rvec1_ff, rvec2_ff;
   logic        sqr_valid_ff, sum_valid_ff;
   logic [63:0] sqr_ff [3];
   logic [63:0] sqr_in [3];
   logic [63:0] sum_ff;
   logic [31:0] mag0 [3];

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         mag0[l]   = umag32(rvec0_ff[95-32*l -: 32]);
         sqr_in[l] = 64'(mag0[l]) * 64'(mag0[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         sqr_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= start;
         sqr_valid_ff <= in_valid_ff;
         sum_valid_ff <= sqr_valid_ff;
      end
      rvec0_ff <= {req_rot_x, req_rot_y, req_rot_z};
      rvec1_ff <= rvec0_ff;
      rvec2_ff <= rvec1_ff;
      for (int l = 0; l < 3; l++) sqr_ff[l] <= sqr_in[l];
      sum_ff <= sqr_ff[0] + sqr_ff[1] + sqr_ff[2];
   end

   // ---------------- theta = isqrt(sum) ----------------
   logic        s1_valid [0:32];
   logic [63:0] s1_v     [0:32];
   logic [63:0] s1_r     [0:32];
   logic [95:0] s1_side  [0:32];

   assign s1_valid[0] = sum_valid_ff;
   assign s1_v[0]     = sum_ff;
   assign s1_r[0]     = '0;
   assign s1_side[0]  = rvec2_ff;

   for (genvar g = 0; g < 32; g++) begin : g_root1
      rvq_sqrt_cell #(.STEP(g), .SW(96)) u_cell (
         .clock(clock), .reset(reset),
         .up_valid(s1_valid[g]), .up_v(s1_v[g]), .up_r(s1_r[g]), .up_side(s1_side[g]),
         .dn_valid(s1_valid[g+1]), .dn_v(s1_v[g+1]), .dn_r(s1_r[g+1]),
         .dn_side(s1_side[g+1])
      );
   end

   // ---------------- axis k = |r| / theta ----------------
   logic                 kd_valid [0:31];
   logic [2:0][61:0]     kd_num   [0:31];
   logic [31:0]          kd_den   [0:31];
   logic [2:0][30:0]     kd_quo   [0:31];
   logic [34:0]          kd_side  [0:31];
   logic [31:0]          theta0;
   logic [2:0]           sign0;

   always_comb begin
      theta0 = s1_r[32][31:0];
      for (int l = 0; l < 3; l++) begin
         sign0[l]     = s1_side[32][95-32*l];
         kd_num[0][l] = {umag32(s1_side[32][95-32*l -: 32]), 30'd0};
         kd_quo[0][l] = '0;
      end
   end

   assign kd_valid[0] = s1_valid[32];
   assign kd_den[0]   = theta0;
   assign kd_side[0]  = {theta0, sign0};

   for (genvar g = 0; g < 31; g++) begin : g_kdiv
      rvq_div_cell #(.BIT(30 - g), .NW(62), .DW(32), .QW(31), .LANES(3), .SW(35)) u_cell (
         .clock(clock), .reset(reset),
         .up_valid(kd_valid[g]), .up_num(kd_num[g]), .up_den(kd_den[g]),
         .up_quo(kd_quo[g]), .up_side(kd_side[g]),
         .dn_valid(kd_valid[g+1]), .dn_num(kd_num[g+1]), .dn_den(kd_den[g+1]),
         .dn_quo(kd_quo[g+1]), .dn_side(kd_side[g+1])
      );
   end

   // ---------------- angle reduction modulo 2*pi, then fold ----------------
   logic        m1_valid_ff, m2_valid_ff;
   logic [37:0] m1_a_ff, m1_a_in, m2_a_in;
   logic [32:0] m2_a_ff;
   logic [95:0] m1_k_ff, m2_k_ff, k_in;
   logic        m1_zero_ff, m2_zero_ff;
   logic [31:0] kq;
   logic signed [33:0] a_red, a_fold;
   logic        flip;

   always_comb begin
      m1_a_in = {kd_side[31][34:3], 6'd0};
      for (int s = 5; s >= 3; s--) begin
         if (m1_a_in >= (TWO_PI_38 << s)) m1_a_in = m1_a_in - (TWO_PI_38 << s);
      end
      for (int l = 0; l < 3; l++) begin
         kq = {1'b0, kd_quo[31][l]};
         k_in[95-32*l -: 32] = kd_side[31][l] ? 32'(-kq) : kq;
      end
      m2_a_in = m1_a_ff;
      for (int s = 2; s >= 0; s--) begin
         if (m2_a_in >= (TWO_PI_38 << s)) m2_a_in = m2_a_in - (TWO_PI_38 << s);
      end
      // into (-pi, pi], then into [-pi/2, pi/2] with a sign flip of c and s
      a_red = $signed({1'b0, m2_a_ff});
      if (a_red > PI) a_red = a_red - TWO_PI;
      a_fold = a_red;
      flip   = 1'b0;
      if (a_red > HALF_PI) begin
         a_fold = a_red - PI;
         flip   = 1'b1;
      end else if (a_red < -HALF_PI) begin
         a_fold = a_red + PI;
         flip   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= kd_valid[31];
         m2_valid_ff <= m1_valid_ff;
      end
      m1_a_ff    <= m1_a_in;
      m1_k_ff    <= k_in;
      m1_zero_ff <= (kd_side[31][34:3] == 32'd0);
      m2_a_ff    <= m2_a_in[32:0];
      m2_k_ff    <= m1_k_ff;
      m2_zero_ff <= m1_zero_ff;
   end

   // ---------------- CORDIC chain ----------------
   logic           cd_valid [0:CORDIC_STEPS];
   cordic_vec_type cd_vec   [0:CORDIC_STEPS];
   logic [CSW-1:0] cd_side  [0:CORDIC_STEPS];
   logic           fold_valid_ff;
   cordic_vec_type fold_vec_ff;
   logic [CSW-1:0] fold_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
      end else begin
         fold_valid_ff <= m2_valid_ff;
      end
      fold_vec_ff.x <= CORDIC_GAIN;
      fold_vec_ff.y <= '0;
      fold_vec_ff.a <= a_fold;
      fold_side_ff  <= {m2_k_ff, flip, m2_zero_ff};
   end

   assign cd_valid[0] = fold_valid_ff;
   assign cd_vec[0]   = fold_vec_ff;
   assign cd_side[0]  = fold_side_ff;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      rvq_cordic_cell #(.STEP(g), .SW(CSW)) u_cell (
         .clock(clock), .reset(reset),
         .up_valid(cd_valid[g]), .up_vec(cd_vec[g]), .up_side(cd_side[g]),
         .dn_valid(cd_valid[g+1]), .dn_vec(cd_vec[g+1]), .dn_side(cd_side[g+1])
      );
   end

   // ---------------- Rodrigues matrix ----------------
   logic               ma_valid_ff, mb_valid_ff, mc_valid_ff;
   logic signed [33:0] cx_in, sy_in;
   logic signed [34:0] t_val;
   logic signed [31:0] kk [3];
   logic signed [66:0] prod_t;
   logic signed [65:0] prod_s;
   logic signed [67:0] prod_p;
   logic signed [35:0] tk_in [3], tk_ff [3];
   logic signed [33:0] sk_in [3], ska_ff [3], skb_ff [3];
   logic signed [31:0] ka_ff [3];
   logic signed [33:0] cxa_ff, cxb_ff;
   logic               za_ff, zb_ff;
   logic signed [35:0] p_in [3][3], p_ff [3][3];
   logic signed [37:0] d_in [3];
   logic signed [39:0] tr_sum;
   logic [33:0]        tr_in;
   logic [113:0]       dvec_ff;
   logic [33:0]        tr_ff;

   always_comb begin
      cx_in = cd_side[CORDIC_STEPS][1] ? -cd_vec[CORDIC_STEPS].x : cd_vec[CORDIC_STEPS].x;
      sy_in = cd_side[CORDIC_STEPS][1] ? -cd_vec[CORDIC_STEPS].y : cd_vec[CORDIC_STEPS].y;
      t_val = 35'(ONE_Q30) - 35'(cx_in);
      for (int l = 0; l < 3; l++) begin
         kk[l]    = $signed(cd_side[CORDIC_STEPS][97-32*l -: 32]);
         prod_t   = t_val * kk[l];
         tk_in[l] = 36'(prod_t >>> 30);
         prod_s   = sy_in * kk[l];
         sk_in[l] = 34'(prod_s >>> 30);
      end
      prod_p = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_p    = tk_ff[i] * ka_ff[j];
            p_in[i][j] = 36'(prod_p >>> 30);
         end
      end
      // skew part enters the off-diagonal pairs
      d_in[0] = (38'(p_ff[2][1]) + 38'(skb_ff[0])) - (38'(p_ff[1][2]) - 38'(skb_ff[0]));
      d_in[1] = (38'(p_ff[0][2]) + 38'(skb_ff[1])) - (38'(p_ff[2][0]) - 38'(skb_ff[1]));
      d_in[2] = (38'(p_ff[1][0]) + 38'(skb_ff[2])) - (38'(p_ff[0][1]) - 38'(skb_ff[2]));
      tr_sum  = 40'(p_ff[0][0]) + 40'(p_ff[1][1]) + 40'(p_ff[2][2])
              + 40'(cxb_ff) + 40'(cxb_ff) + 40'(cxb_ff) + ONE_Q30;
      if (tr_sum < 0) begin
         tr_in = '0;
      end else if (tr_sum > TR_MAX) begin
         tr_in = 34'(TR_MAX);
      end else begin
         tr_in = tr_sum[33:0];
      end
      // zero angle: identity matrix
      if (zb_ff) begin
         for (int l = 0; l < 3; l++) d_in[l] = '0;
         tr_in = 34'(ONE_Q30 <<< 2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ma_valid_ff <= 1'b0;
         mb_valid_ff <= 1'b0;
         mc_valid_ff <= 1'b0;
      end else begin
         ma_valid_ff <= cd_valid[CORDIC_STEPS];
         mb_valid_ff <= ma_valid_ff;
         mc_valid_ff <= mb_valid_ff;
      end
      for (int l = 0; l < 3; l++) begin
         tk_ff[l]  <= tk_in[l];
         ska_ff[l] <= sk_in[l];
         ka_ff[l]  <= kk[l];
         skb_ff[l] <= ska_ff[l];
      end
      cxa_ff <= cx_in;
      za_ff  <= cd_side[CORDIC_STEPS][0];
      cxb_ff <= cxa_ff;
      zb_ff  <= za_ff;
      p_ff   <= p_in;
      dvec_ff <= {d_in[0], d_in[1], d_in[2]};
      tr_ff   <= tr_in;
   end

   // ---------------- s = isqrt(trace + 1) ----------------
   logic         s2_valid [0:32];
   logic [63:0]  s2_v     [0:32];
   logic [63:0]  s2_r     [0:32];
   logic [113:0] s2_side  [0:32];

   assign s2_valid[0] = mc_valid_ff;
   assign s2_v[0]     = {tr_ff, 30'd0};
   assign s2_r[0]     = '0;
   assign s2_side[0]  = dvec_ff;

   for (genvar g = 0; g < 32; g++) begin : g_root2
      rvq_sqrt_cell #(.STEP(g), .SW(114)) u_cell (
         .clock(clock), .reset(reset),
         .up_valid(s2_valid[g]), .up_v(s2_v[g]), .up_r(s2_r[g]), .up_side(s2_side[g]),
         .dn_valid(s2_valid[g+1]), .dn_v(s2_v[g+1]), .dn_r(s2_r[g+1]),
         .dn_side(s2_side[g+1])
      );
   end

   // ---------------- quotient setup: clamp, sign, overflow flag ----------------
   logic               qs_valid_ff;
   logic [2:0][63:0]   qs_num_ff, qs_num_in;
   logic [32:0]        qs_den_ff, qs_den_in;
   logic [38:0]        qs_side_ff;
   logic [2:0]         neg_in, big_in;
   logic signed [37:0] dd;
   logic [37:0]        dmag;
   logic [33:0]        dclamp;
   logic [31:0]        sq_val;

   always_comb begin
      sq_val    = s2_r[32][31:0];
      qs_den_in = {sq_val, 1'b0};
      for (int l = 0; l < 3; l++) begin
         dd     = $signed(s2_side[32][113-38*l -: 38]);
         neg_in[l] = dd[37];
         dmag   = dd[37] ? 38'(-dd) : 38'(dd);
         dclamp = (dmag > 38'h2_0000_0000) ? 34'h2_0000_0000 : dmag[33:0];
         qs_num_in[l] = {dclamp, 30'd0};
         big_in[l] = {1'b0, qs_num_in[l]} >= {qs_den_in, 32'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qs_valid_ff <= 1'b0;
      end else begin
         qs_valid_ff <= s2_valid[32];
      end
      qs_num_ff  <= qs_num_in;
      qs_den_ff  <= qs_den_in;
      qs_side_ff <= {sq_val, sq_val < S_MIN, big_in, neg_in};
   end

   // ---------------- quotient chain ----------------
   logic             qd_valid [0:32];
   logic [2:0][63:0] qd_num   [0:32];
   logic [32:0]      qd_den   [0:32];
   logic [2:0][31:0] qd_quo   [0:32];
   logic [38:0]      qd_side  [0:32];

   assign qd_valid[0] = qs_valid_ff;
   assign qd_num[0]   = qs_num_ff;
   assign qd_den[0]   = qs_den_ff;
   assign qd_quo[0]   = '0;
   assign qd_side[0]  = qs_side_ff;

   for (genvar g = 0; g < 32; g++) begin : g_qdiv
      rvq_div_cell #(.BIT(31 - g), .NW(64), .DW(33), .QW(32), .LANES(3), .SW(39)) u_cell (
         .clock(clock), .reset(reset),
         .up_valid(qd_valid[g]), .up_num(qd_num[g]), .up_den(qd_den[g]),
         .up_quo(qd_quo[g]), .up_side(qd_side[g]),
         .dn_valid(qd_valid[g+1]), .dn_num(qd_num[g+1]), .dn_den(qd_den[g+1]),
         .dn_quo(qd_quo[g+1]), .dn_side(qd_side[g+1])
      );
   end

   // ---------------- output register ----------------
   logic               rsp_valid_ff;
   logic [31:0]        qx_ff, qy_ff, qz_ff, qw_ff;
   logic               degen_ff;
   logic [31:0]        q_in [3];
   logic [31:0]        qw_in;
   logic [32:0]        qmag;
   logic signed [33:0] qsig;
   logic               degen_in;

   always_comb begin
      degen_in = qd_side[32][6];
      for (int l = 0; l < 3; l++) begin
         qmag = qd_side[32][3+l] ? 33'h1_0000_0000 : {1'b0, qd_quo[32][l]};
         qsig = qd_side[32][l] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
         if (qsig > 34'sh0_7FFF_FFFF) begin
            q_in[l] = 32'h7FFF_FFFF;
         end else if (qsig < -34'sh0_8000_0000) begin
            q_in[l] = 32'h8000_0000;
         end else begin
            q_in[l] = qsig[31:0];
         end
      end
      qw_in = {1'b0, qd_side[32][38:8]};
      // s too small: identity quaternion
      if (degen_in) begin
         for (int l = 0; l < 3; l++) q_in[l] = '0;
         qw_in = ONE_Q30[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= qd_valid[32];
      end
      qx_ff    <= q_in[0];
      qy_ff    <= q_in[1];
      qz_ff    <= q_in[2];
      qw_ff    <= qw_in;
      degen_ff <= degen_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_quat_x     = qx_ff;
   assign rsp_quat_y     = qy_ff;
   assign rsp_quat_z     = qz_ff;
   assign rsp_quat_w     = qw_ff;
   assign rsp_degenerate = degen_ff;

   // ---------------- assertions ----------------
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("transaction result missing at fixed latency");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching transaction");

   a_degen_ident: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> (rsp_quat_x == 32'd0 && rsp_quat_y == 32'd0
         && rsp_quat_z == 32'd0 && rsp_quat_w == 32'd1073741824))
      else $error("degenerate result is not the identity");

   a_w_nonneg: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_degenerate) |-> !rsp_quat_w[31])
      else $error("scalar part negative");

endmodule

@@ hw/rtl/rvq_sqrt_cell.sv @@
// One restoring step of a 64-bit integer square root.
module rvq_sqrt_cell #(
   parameter int STEP = 0,
   parameter int SW   = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   input  logic [63:0]   up_v,
   input  logic [63:0]   up_r,
   input  logic [SW-1:0] up_side,
   output logic          dn_valid,
   output logic [63:0]   dn_v,
   output logic [63:0]   dn_r,
   output logic [SW-1:0] dn_side
);

   localparam logic [63:0] BIT_VAL = 64'd1 << (62 - 2 * STEP);

   logic [63:0] trial;
   logic        fit;
   logic [63:0] v_in, r_in;
   logic        valid_ff;
   logic [63:0] v_ff, r_ff;
   logic [SW-1:0] side_ff;

   always_comb begin
      trial = up_r + BIT_VAL;
      fit   = up_v >= trial;
      v_in  = fit ? up_v - trial : up_v;
      r_in  = fit ? (up_r >> 1) + BIT_VAL : up_r >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
      v_ff    <= v_in;
      r_ff    <= r_in;
      side_ff <= up_side;
   end

   assign dn_valid = valid_ff;
   assign dn_v     = v_ff;
   assign dn_r     = r_ff;
   assign dn_side  = side_ff;

endmodule

@@ hw/rtl/rvq_div_cell.sv @@
// One quotient bit of a restoring divider, several lanes sharing a divisor.
module rvq_div_cell #(
   parameter int BIT   = 0,
   parameter int NW    = 64,
   parameter int DW    = 33,
   parameter int QW    = 32,
   parameter int LANES = 3,
   parameter int SW    = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      up_valid,
   input  logic [LANES-1:0][NW-1:0]  up_num,
   input  logic [DW-1:0]             up_den,
   input  logic [LANES-1:0][QW-1:0]  up_quo,
   input  logic [SW-1:0]             up_side,
   output logic                      dn_valid,
   output logic [LANES-1:0][NW-1:0]  dn_num,
   output logic [DW-1:0]             dn_den,
   output logic [LANES-1:0][QW-1:0]  dn_quo,
   output logic [SW-1:0]             dn_side
);

   localparam int CW = NW + DW + 1;

   logic [CW-1:0]              step_den;
   logic [CW-1:0]              ext;
   logic [LANES-1:0][NW-1:0]   num_in;
   logic [LANES-1:0][QW-1:0]   quo_in;
   logic                       valid_ff;
   logic [LANES-1:0][NW-1:0]   num_ff;
   logic [DW-1:0]              den_ff;
   logic [LANES-1:0][QW-1:0]   quo_ff;
   logic [SW-1:0]              side_ff;

   always_comb begin
      step_den = CW'(up_den) << BIT;
      ext      = '0;
      for (int l = 0; l < LANES; l++) begin
         ext       = CW'(up_num[l]);
         num_in[l] = up_num[l];
         quo_in[l] = up_quo[l];
         if (ext >= step_den) begin
            num_in[l]      = NW'(ext - step_den);
            quo_in[l][BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
      num_ff  <= num_in;
      den_ff  <= up_den;
      quo_ff  <= quo_in;
      side_ff <= up_side;
   end

   assign dn_valid = valid_ff;
   assign dn_num   = num_ff;
   assign dn_den   = den_ff;
   assign dn_quo   = quo_ff;
   assign dn_side  = side_ff;

endmodule

@@ hw/rtl/rvq_cordic_cell.sv @@
// One CORDIC rotation-mode micro-rotation.
module rvq_cordic_cell import rvq_pkg::*; #(
   parameter int STEP = 0,
   parameter int SW   = 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           up_valid,
   input  cordic_vec_type up_vec,
   input  logic [SW-1:0]  up_side,
   output logic           dn_valid,
   output cordic_vec_type dn_vec,
   output logic [SW-1:0]  dn_side
);

   localparam logic [31:0] ATAN_TAB [32] = '{
      32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
      32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
      32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
      32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
      32'd127, 32'd63, 32'd31, 32'd15, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
   };
   localparam logic signed [33:0] ANGLE = $signed({2'b00, ATAN_TAB[STEP]});

   logic signed [33:0] dx, dy;
   cordic_vec_type     vec_in;
   logic               valid_ff;
   cordic_vec_type     vec_ff;
   logic [SW-1:0]      side_ff;

   always_comb begin
      dx = $signed(up_vec.y) >>> STEP;
      dy = $signed(up_vec.x) >>> STEP;
      if (!up_vec.a[33]) begin
         vec_in.x = up_vec.x - dx;
         vec_in.y = up_vec.y + dy;
         vec_in.a = up_vec.a - ANGLE;
      end else begin
         vec_in.x = up_vec.x + dx;
         vec_in.y = up_vec.y - dy;
         vec_in.a = up_vec.a + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
      vec_ff  <= vec_in;
      side_ff <= up_side;
   end

   assign dn_valid = valid_ff;
   assign dn_vec   = vec_ff;
   assign dn_side  = side_ff;

endmodule
